// ----- rtl/srxf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxf_pkg: shared types and constants
// Item operation codes, back-end action codes and queue status for the serial
// receive FIFO with idle-timeout flush.
// ----------------------------------------------------------------------------
package srxf_pkg;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } act_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int TIMER_W     = 16;
    localparam int TIMEOUT_W   = 8;
    localparam int BYTE_W      = 8;

endpackage

// ----- rtl/srxf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxf_if: item channels
// Valid/ready channels for incoming items and outgoing flushed bytes.
// ----------------------------------------------------------------------------
interface srxf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic       device_configured;
    logic       endpoint_ready;
    logic       send_ok;

    modport source (output valid, operation, rx_byte, device_configured,
                    endpoint_ready, send_ok, input ready);
    modport sink   (input valid, operation, rx_byte, device_configured,
                    endpoint_ready, send_ok, output ready);
endinterface

interface srxf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_flush;

    modport source (output valid, data_byte, last_of_flush, input ready);
    modport sink   (input valid, data_byte, last_of_flush, output ready);
endinterface

// ----- rtl/srxf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxf_front: item decode and FIFO bookkeeping
// Accepts one item a cycle unless the queue is full; keeps pointers, fill
// count, gap timer, timeout, flush run state; issues store writes and reads.
// ----------------------------------------------------------------------------
module srxf_front
    import srxf_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024,
    parameter int ADDR_W     = $clog2(FIFO_DEPTH),
    parameter int CMD_W      = 1 + ADDR_W + BYTE_W + 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    srxf_in_if.sink           in_ch,
    input  q_stat_t           q_stat,
    output logic              push,
    output logic [CMD_W-1:0]  push_cmd
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0]  HALF_C  = CNT_W'(FIFO_DEPTH / 2);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(FIFO_DEPTH - 1);

    logic [ADDR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [TIMER_W-1:0]   gap_reg, gap_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic                 accept;

    assign in_ch.ready = ~q_stat.full;
    assign accept      = in_ch.valid & in_ch.ready;

    always_comb
    begin
        logic [CNT_W-1:0] remain;
        logic             go;
        logic             due;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        fill_next    = fill_reg;
        gap_next     = gap_reg;
        timeout_next = timeout_reg;
        remain_next  = remain_reg;
        push         = 1'b0;
        push_cmd     = {ACT_WRITE, wr_ptr_reg, in_ch.rx_byte, 1'b0};
        remain       = remain_reg;
        go           = 1'b1;
        due          = ((fill_reg != '0) && (gap_reg >= TIMER_W'(timeout_reg)))
                       || (fill_reg > HALF_C);
        if (accept)
        begin
            case (op_t'(in_ch.operation))
                OP_BYTE:
                begin
                    if (in_ch.device_configured && (fill_reg != DEPTH_C))
                    begin
                        // Four times the gap, truncated to the timeout width.
                        if (fill_reg != '0)
                            timeout_next = {gap_reg[TIMEOUT_W-3:0], 2'b00};
                        gap_next    = '0;
                        push        = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == LAST_A) ? '0 : wr_ptr_reg + 1'b1;
                        fill_next   = fill_reg + 1'b1;
                    end
                end
                OP_TICK:
                begin
                    gap_next = gap_reg + 1'b1;
                end
                OP_POLL:
                begin
                    if (remain_reg == '0)
                    begin
                        if (due && in_ch.endpoint_ready)
                            remain = fill_reg;
                        else
                            go = 1'b0;
                    end
                    if (go)
                    begin
                        if (!in_ch.send_ok || (fill_reg == '0))
                        begin
                            remain_next = '0;
                        end
                        else
                        begin
                            remain_next = remain - 1'b1;
                            push        = 1'b1;
                            push_cmd    = {ACT_READ, rd_ptr_reg, in_ch.rx_byte,
                                           (remain_next == '0)};
                            rd_ptr_next = (rd_ptr_reg == LAST_A) ? '0 : rd_ptr_reg + 1'b1;
                            fill_next   = fill_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            gap_reg     <= '0;
            timeout_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
            gap_reg     <= gap_next;
            timeout_reg <= timeout_next;
            remain_reg  <= remain_next;
        end
    end

endmodule

// ----- rtl/srxf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxf_queue: command queue
// Short register queue that decouples the front end from the store and the
// output register.
// ----------------------------------------------------------------------------
module srxf_queue
    import srxf_pkg::*;
#(
    parameter int CMD_W = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [CMD_W-1:0] push_cmd,
    input  logic             pop,
    output logic [CMD_W-1:0] head_cmd,
    output q_stat_t          q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CMD_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_cmd     = slot_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/srxf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srxf_back: byte store and output register
// Carries out queued store writes and reads in order; read data lands in the
// output register that drives the result channel.
// ----------------------------------------------------------------------------
module srxf_back
    import srxf_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024,
    parameter int ADDR_W     = $clog2(FIFO_DEPTH),
    parameter int CMD_W      = 1 + ADDR_W + BYTE_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] head_cmd,
    input  q_stat_t          q_stat,
    output logic             pop,
    srxf_out_if.source       out_ch
);

    logic [BYTE_W-1:0] store [FIFO_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              last_reg;
    logic              valid_reg, valid_next;
    act_t              act;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    logic              last_flag;

    assign {act, addr, wdata, last_flag} = head_cmd;

    // A write never waits; a read waits until the output register is free.
    assign pop = ~q_stat.empty
                 & ((act == ACT_WRITE) | ~valid_reg | out_ch.ready);

    assign out_ch.valid         = valid_reg;
    assign out_ch.data_byte     = rdata_reg;
    assign out_ch.last_of_flush = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop && (act == ACT_READ))
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && (act == ACT_WRITE))
            store[addr] <= wdata;
        if (pop && (act == ACT_READ))
        begin
            rdata_reg <= store[addr];
            last_reg  <= last_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

// ----- rtl/serial_rx_fifo_timeout_flush_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_rx_fifo_timeout_flush_unit: serial receive FIFO with timeout flush
// A drain poll's read is registered in the command queue and its byte in the
// output register before it is valid, later if commands wait ahead of it.
// Throughput: one item per cycle, set by the single-ported store doing one
// access a cycle; a stalled output stops input only once the queue is full.
// Reset: asynchronous, active low; pointers, counts, timer, timeout and run
// state clear at once; the byte store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module serial_rx_fifo_timeout_flush_unit
    import srxf_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    srxf_in_if.sink     in_ch,
    srxf_out_if.source  out_ch
);

    localparam int ADDR_W = $clog2(FIFO_DEPTH);
    localparam int CMD_W  = 1 + ADDR_W + BYTE_W + 1;

    logic             push;
    logic [CMD_W-1:0] push_cmd;
    logic             pop;
    logic [CMD_W-1:0] head_cmd;
    q_stat_t          q_stat;

    srxf_front #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .ADDR_W     (ADDR_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    srxf_queue #(
        .CMD_W (CMD_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    srxf_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .ADDR_W     (ADDR_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .out_ch   (out_ch)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from an empty queue");

    a_valid_from_read : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(pop && head_cmd[CMD_W-1]))
        else $error("output became valid without a store read");

endmodule

// ----- dv/serial_rx_fifo_timeout_flush_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_rx_fifo_timeout_flush_unit_test: self-checking bench for the serial
// receive FIFO with idle-timeout flush
// A short scripted sequence is followed by random byte messages, timer ticks
// and drain polls. The input is driven in bursts and the output stalls at
// random. A full-FIFO flood is included. Every flushed byte is compared with
// the script's expected byte or a behavioural model kept inside the bench.
// ----------------------------------------------------------------------------
module serial_rx_fifo_timeout_flush_unit_test;
    import srxf_pkg::*;

    localparam int         DEPTH         = 1024;
    localparam int         PTR_W         = $clog2(DEPTH);
    localparam int         RANDOM_ITEMS  = 400;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         SCRIPT_LEN    = 21;
    localparam logic [1:0] OP_SPARE      = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] value;
        logic              linked;
        logic              sink_ready;
        logic              accept;
    } rx_item_t;

    typedef struct packed {
        logic              present;
        logic [BYTE_W-1:0] data;
        logic              last;
    } flush_byte_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_BYTE,
        GIVES_BYTE
    } script_check_t;

    typedef struct packed {
        rx_item_t          item;
        script_check_t     how;
        logic [BYTE_W-1:0] data;
        logic              last;
    } script_row_t;

    logic clk;
    logic rst_n;

    srxf_in_if  in_ch ();
    srxf_out_if out_ch ();

    serial_rx_fifo_timeout_flush_unit #(
        .FIFO_DEPTH (DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Behavioural copy of the FIFO and its flush state.
    logic [BYTE_W-1:0]    byte_mem [DEPTH];
    logic [PTR_W-1:0]     rd_ptr;
    logic [PTR_W-1:0]     wr_ptr;
    logic [PTR_W:0]       held;
    logic [PTR_W:0]       run_left;
    logic [TIMER_W-1:0]   gap_ticks;
    logic [TIMEOUT_W-1:0] flush_lim;

    flush_byte_t bytes_due [$];

    int failures    = 0;
    int stim_count  = 0;
    int burst_left  = 0;
    int holds_asked = 0;

    script_row_t script [SCRIPT_LEN] = '{
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_BYTE,  8'h00, 1'b0, 1'b1, 1'b1}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_SPARE, 8'hFF, 1'b1, 1'b1, 1'b1}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_BYTE,  8'hFF, 1'b1, 1'b0, 1'b0}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b0, 1'b1}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b0}, NO_BYTE,    8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, GIVES_BYTE, 8'hFF, 1'b1},
        '{'{OP_BYTE,  8'h00, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_TICK,  8'hFF, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_BYTE,  8'h80, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_BYTE,  8'h01, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_BYTE,  8'h7F, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b0, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b0}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, BY_MODEL,   8'h00, 1'b0},
        '{'{OP_POLL,  8'h00, 1'b1, 1'b1, 1'b1}, NO_BYTE,    8'h00, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("serial_rx_fifo_timeout_flush_unit_test NOT OK");
        $finish;
    end

    function automatic rx_item_t make_item(input logic [1:0] opcode,
                                           input logic [BYTE_W-1:0] value,
                                           input logic linked,
                                           input logic sink_ready,
                                           input logic accept);
        rx_item_t it;
        it.opcode     = opcode;
        it.value      = value;
        it.linked     = linked;
        it.sink_ready = sink_ready;
        it.accept     = accept;
        return it;
    endfunction

    function automatic rx_item_t tick_item();
        return make_item(OP_TICK, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic rx_item_t good_byte();
        return make_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)), 1'b1,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic rx_item_t poll_item(input logic accept);
        return make_item(OP_POLL, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'b1, accept);
    endfunction

    // Advances the model by one item and returns the flushed byte, if any.
    function automatic flush_byte_t predict_flush(input rx_item_t it);
        flush_byte_t res;
        res = '0;
        case (it.opcode)
            OP_BYTE:
            begin
                if (it.linked && held != DEPTH)
                begin
                    if (held != 0)
                        flush_lim = {gap_ticks[TIMEOUT_W-3:0], 2'b00};
                    gap_ticks        = '0;
                    byte_mem[wr_ptr] = it.value;
                    wr_ptr           = wr_ptr + 1'b1;
                    held             = held + 1'b1;
                end
            end
            OP_TICK:
                gap_ticks = gap_ticks + 1'b1;
            OP_POLL:
            begin
                if (run_left == 0)
                begin
                    if (!it.sink_ready ||
                        !((held != 0 && gap_ticks >= flush_lim) || held > DEPTH / 2))
                        return res;
                    run_left = held;
                end
                if (!it.accept || held == 0)
                    run_left = '0;
                else
                begin
                    res.present = 1'b1;
                    res.data    = byte_mem[rd_ptr];
                    rd_ptr      = rd_ptr + 1'b1;
                    held        = held - 1'b1;
                    run_left    = run_left - 1'b1;
                    res.last    = (run_left == 0);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offers one item, waits for the handshake and records what it should flush.
    // A paced item may be preceded by a gap that closes the current burst.
    task automatic offer(input rx_item_t it, input bit paced = 1'b1,
                         input script_check_t how = BY_MODEL,
                         input flush_byte_t typed = '0);
        flush_byte_t got;
        if (paced)
        begin
            if (burst_left == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
            end
            burst_left--;
        end
        in_ch.valid             <= 1'b1;
        in_ch.operation         <= it.opcode;
        in_ch.rx_byte           <= it.value;
        in_ch.device_configured <= it.linked;
        in_ch.endpoint_ready    <= it.sink_ready;
        in_ch.send_ok           <= it.accept;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        got = predict_flush(it);
        if (how == GIVES_BYTE)
            bytes_due.push_back(typed);
        else if (how == BY_MODEL && got.present)
            bytes_due.push_back(got);
        if (it.opcode != OP_SPARE)
            stim_count++;
    endtask

    task automatic wait_flushed();
        in_ch.valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Polls until the FIFO is empty, ticking the timer whenever no run is due.
    task automatic drain_all();
        while (held != 0)
        begin
            offer(poll_item(1'b1));
            if (run_left == 0 && held != 0)
                offer(tick_item());
        end
    endtask

    task automatic run_message();
        int n;
        int k;
        int polls;
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
        begin
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(20, 90)
                                                : $urandom_range(0, 6))
                offer(tick_item());
            offer(make_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)),
                            $urandom_range(0, 15) != 0,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 8))
            offer(tick_item());
        polls = n + $urandom_range(0, 4);
        for (k = 0; k < polls; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                offer($urandom_range(0, 1) ? good_byte() : tick_item());
            offer(make_item(OP_POLL, BYTE_W'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)),
                            $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0));
        end
    endtask

    // Fills the FIFO to the brim, then drains it against a long output stall.
    // The last byte sets a timeout of 120 ticks, so runs below start only on
    // the more-than-half-full rule until the timer is ticked up to it.
    task automatic flood_fifo();
        drain_all();
        while (held < DEPTH - 1)
            offer(good_byte());
        repeat (30) offer(tick_item());
        offer(good_byte());
        // The FIFO is full now, so these bytes must be dropped.
        repeat (4) offer(good_byte());
        holds_asked++;
        repeat (DEPTH / 2 - 1) offer(poll_item(1'b1));
        offer(poll_item(1'b0));
        offer(poll_item(1'b1));
        offer(poll_item(1'b0));
        // Exactly half full with the timer short of the timeout: nothing is due.
        repeat (4) offer(poll_item(1'b1));
        repeat (120) offer(tick_item());
        drain_all();
    endtask

    always @(posedge clk)
    begin
        flush_byte_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (bytes_due.size() == 0)
            begin
                $error("data_byte: expected none, got %02h", out_ch.data_byte);
                failures++;
            end
            else
            begin
                want = bytes_due.pop_front();
                if (out_ch.data_byte !== want.data)
                begin
                    $error("data_byte: expected %02h, got %02h", want.data, out_ch.data_byte);
                    failures++;
                end
                if (out_ch.last_of_flush !== want.last)
                begin
                    $error("last_of_flush: expected %0b, got %0b",
                           want.last, out_ch.last_of_flush);
                    failures++;
                end
            end
        end
    end

    // The receiver switches to a new random stall rate now and then, and serves
    // each request for a long hold-off by keeping ready low throughout it.
    initial
    begin
        int span;
        int stall_pct;
        int holds_served;
        int hold_left;
        span         = 0;
        stall_pct    = 0;
        holds_served = 0;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    span = $urandom_range(8, 90);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 25;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                span--;
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    initial
    begin
        int  k;
        int  item_base;
        int  phase_base;
        bit  flooded;
        in_ch.valid             <= 1'b0;
        in_ch.operation         <= OP_TICK;
        in_ch.rx_byte           <= '0;
        in_ch.device_configured <= 1'b0;
        in_ch.endpoint_ready    <= 1'b0;
        in_ch.send_ok           <= 1'b0;
        rst_n                   <= 1'b0;
        rd_ptr    = '0;
        wr_ptr    = '0;
        held      = '0;
        run_left  = '0;
        gap_ticks = '0;
        flush_lim = '0;
        flooded   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < SCRIPT_LEN; k++)
            offer(script[k].item, 1'b1, script[k].how,
                  flush_byte_t'{1'b1, script[k].data, script[k].last});
        wait_flushed();

        // The flood is extra to the random item count.
        item_base = stim_count;
        while (stim_count - item_base < RANDOM_ITEMS)
        begin
            phase_base = stim_count;
            if (!flooded && stim_count - item_base >= RANDOM_ITEMS / 3)
            begin
                flood_fifo();
                flooded   = 1'b1;
                item_base += stim_count - phase_base;
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                        run_message();
                    10, 11, 12:
                        repeat ($urandom_range(4, 20))
                            offer(make_item(2'($urandom_range(0, 3)),
                                            BYTE_W'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))));
                    13, 14:
                        drain_all();
                    default:
                        wait_flushed();
                endcase
            end
        end

        wait_flushed();
        if (failures == 0)
            $display("serial_rx_fifo_timeout_flush_unit_test OK");
        else
            $display("serial_rx_fifo_timeout_flush_unit_test NOT OK");
        $finish;
    end

endmodule
